@@ rtl/core/rqn_pkg.sv @@
// shared types and coefficients for the rgb565 quad to nv12 converter
package rqn_pkg;

    // input item: one 2x2 block of rgb565 words
    typedef struct packed {
        logic [15:0] pix_top_left;
        logic [15:0] pix_top_right;
        logic [15:0] pix_bottom_left;
        logic [15:0] pix_bottom_right;
    } rqn_quad_t;

    // result item: four luma bytes and one chroma pair
    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } rqn_yuv_t;

    // per pixel results handed to the chroma averager
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
    } rqn_pix_yuv_t;

    // luma weights (sum to 256)
    localparam logic [7:0] Y_R = 8'd77;
    localparam logic [7:0] Y_G = 8'd150;
    localparam logic [7:0] Y_B = 8'd29;

    // chroma weights, magnitudes
    localparam logic [7:0] U_R = 8'd44;
    localparam logic [7:0] U_G = 8'd87;
    localparam logic [7:0] U_B = 8'd131;
    localparam logic [7:0] V_R = 8'd131;
    localparam logic [7:0] V_G = 8'd110;
    localparam logic [7:0] V_B = 8'd21;

    // chroma offset
    localparam logic [7:0] CHROMA_OFS = 8'd128;

endpackage

@@ rtl/core/rgb565_quad_to_nv12.sv @@
// rgb565 2x2 block to nv12 luma and chroma converter, top level
// an accepted item passes the input register, then the result register, before it shows as a valid result
// throughput: one item per cycle, sustained while the result side is not stalled
// the result register is the only stage after the converter logic
// reset: rst_n async active low clears both valid flags; payload is not reset
module rgb565_quad_to_nv12
    import rqn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      quad_valid,
    output logic      quad_stall,
    input  rqn_quad_t quad,
    output logic      yuv_valid,
    input  logic      yuv_stall,
    output rqn_yuv_t  yuv
);

    logic         in_valid_reg;
    rqn_quad_t    in_data_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    rqn_yuv_t     out_data_reg;
    rqn_yuv_t     out_data_next;
    logic         out_load;
    logic         in_load;
    rqn_pix_yuv_t px_tl;
    rqn_pix_yuv_t px_tr;
    rqn_pix_yuv_t px_bl;
    rqn_pix_yuv_t px_br;
    logic [7:0]   cb_avg;
    logic [7:0]   cr_avg;

    // pipeline advance
    assign out_load   = !out_valid_reg || !yuv_stall;
    assign in_load    = !in_valid_reg || out_load;
    assign quad_stall = !in_load;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= quad_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && quad_valid)
        begin
            in_data_reg <= quad;
        end
    end

    // per pixel conversion
    rqn_pixel u_pix_tl (.pix(in_data_reg.pix_top_left),     .yuv(px_tl));
    rqn_pixel u_pix_tr (.pix(in_data_reg.pix_top_right),    .yuv(px_tr));
    rqn_pixel u_pix_bl (.pix(in_data_reg.pix_bottom_left),  .yuv(px_bl));
    rqn_pixel u_pix_br (.pix(in_data_reg.pix_bottom_right), .yuv(px_br));

    // chroma averaging over the block
    rqn_chroma_avg u_avg (
        .pix_tl (px_tl),
        .pix_tr (px_tr),
        .pix_bl (px_bl),
        .pix_br (px_br),
        .cb_avg (cb_avg),
        .cr_avg (cr_avg)
    );

    // result assembly
    always_comb
    begin
        out_data_next.luma_top_left     = px_tl.luma;
        out_data_next.luma_top_right    = px_tr.luma;
        out_data_next.luma_bottom_left  = px_bl.luma;
        out_data_next.luma_bottom_right = px_br.luma;
        out_data_next.chroma_blue       = cb_avg;
        out_data_next.chroma_red        = cr_avg;
        out_valid_next                  = out_load ? in_valid_reg : out_valid_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign yuv_valid = out_valid_reg;
    assign yuv       = out_data_reg;

endmodule

@@ rtl/core/rqn_pixel.sv @@
// one pixel: rgb565 to luma and per pixel chroma bytes
module rqn_pixel
    import rqn_pkg::*;
(
    input  logic [15:0]  pix,
    output rqn_pix_yuv_t yuv
);

    logic [7:0]         r8;
    logic [7:0]         g8;
    logic [7:0]         b8;
    logic [16:0]        y_sum;
    logic signed [17:0] u_sum;
    logic signed [17:0] v_sum;

    // widen components with zero fill
    assign r8 = {pix[15:11], 3'b000};
    assign g8 = {pix[10:5], 2'b00};
    assign b8 = {pix[4:0], 3'b000};

    // weighted sums
    always_comb
    begin
        y_sum = 17'(Y_R * r8) + 17'(Y_G * g8) + 17'(Y_B * b8);
        u_sum = $signed(18'(U_B * b8)) - $signed(18'(U_R * r8))
              - $signed(18'(U_G * g8));
        v_sum = $signed(18'(V_R * r8)) - $signed(18'(V_G * g8))
              - $signed(18'(V_B * b8));
    end

    // floor shift by 8, then offset, kept modulo 256
    assign yuv.luma = y_sum[15:8];
    assign yuv.cb   = u_sum[15:8] + CHROMA_OFS;
    assign yuv.cr   = v_sum[15:8] + CHROMA_OFS;

endmodule

@@ rtl/core/rqn_chroma_avg.sv @@
// truncated mean of the four per pixel chroma bytes
module rqn_chroma_avg
    import rqn_pkg::*;
(
    input  rqn_pix_yuv_t pix_tl,
    input  rqn_pix_yuv_t pix_tr,
    input  rqn_pix_yuv_t pix_bl,
    input  rqn_pix_yuv_t pix_br,
    output logic [7:0]   cb_avg,
    output logic [7:0]   cr_avg
);

    logic [9:0] cb_sum;
    logic [9:0] cr_sum;

    // sum of four bytes, divide by four by dropping two bits
    always_comb
    begin
        cb_sum = 10'(pix_tl.cb) + 10'(pix_tr.cb) + 10'(pix_bl.cb) + 10'(pix_br.cb);
        cr_sum = 10'(pix_tl.cr) + 10'(pix_tr.cr) + 10'(pix_bl.cr) + 10'(pix_br.cr);
    end

    assign cb_avg = cb_sum[9:2];
    assign cr_avg = cr_sum[9:2];

endmodule

@@ rtl/core/rgb565_quad_to_nv12_chk.sv @@
// port level checker for the rgb565 quad to nv12 converter, with bind
module rgb565_quad_to_nv12_chk
    import rqn_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      quad_valid,
    input logic      quad_stall,
    input logic      yuv_valid,
    input logic      yuv_stall,
    input rqn_yuv_t  yuv
);

    // a stalled result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        yuv_valid && yuv_stall |=> yuv_valid)
        else $error("result valid dropped while stalled");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        yuv_valid && yuv_stall |=> $stable(yuv))
        else $error("result payload changed while stalled");

    // with the result side empty the block never stalls its input
    assert property (@(posedge clk) disable iff (!rst_n)
        !yuv_valid |-> !quad_stall)
        else $error("input stalled with empty result register");

    // every accepted item shows a valid result after the input register and the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        quad_valid && !quad_stall |=> ##1 yuv_valid)
        else $error("accepted item did not reach the result register");

endmodule

bind rgb565_quad_to_nv12 rgb565_quad_to_nv12_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .quad_valid (quad_valid),
    .quad_stall (quad_stall),
    .yuv_valid  (yuv_valid),
    .yuv_stall  (yuv_stall),
    .yuv        (yuv)
);
